FILE: hw/rtl/ast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arpeggiated square tone generator package
// Shared widths, register indexes, command codes, reset values, the
// sequencer state type and the divider status struct.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int NUM_TONES  = 3;
    localparam int TONE_SLOTS = 8;

    localparam int CLK_RATE_W = 24;
    localparam int TONE_W     = 16;
    localparam int SLICE_W    = 8;
    localparam int SAMPLE_W   = 16;
    localparam int WRAP_W     = 16;
    localparam int LEVEL_W    = 15;
    localparam int ACT_W      = 2;
    localparam int PTR_FULL_W = 3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_CLOCK_RATE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLICE_MS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_MS  = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CLK_RATE_W-1:0] CLOCK_RATE_RST = 24'd1000000;
    localparam logic [SLICE_W-1:0]    SLICE_MS_RST   = 8'd20;
    localparam logic [SAMPLE_W-1:0]   SAMPLE_MS_RST  = 16'd250;

    localparam logic [SLICE_W-1:0]  SLICE_MAX   = '1;
    localparam logic [SAMPLE_W-1:0] ELAPSED_MAX = '1;
    localparam logic [WRAP_W-1:0]   WRAP_MAX    = '1;

    // One quotient bit per divider step, over the whole dividend.
    localparam int DIV_STEPS = CLK_RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hw/rtl/ast_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel that carries one command and three tone frequencies.
// ----------------------------------------------------------------------------
interface ast_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [ast_pkg::TONE_W-1:0]  tone_a;
    logic [ast_pkg::TONE_W-1:0]  tone_b;
    logic [ast_pkg::TONE_W-1:0]  tone_c;

    modport source (output valid, cmd, tone_a, tone_b, tone_c, input ready);
    modport sink   (input valid, cmd, tone_a, tone_b, tone_c, output ready);
endinterface

FILE: hw/rtl/ast_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel that carries the PWM settings for the current tone.
// ----------------------------------------------------------------------------
interface ast_out_if;
    logic                         valid;
    logic                         ready;
    logic [ast_pkg::WRAP_W-1:0]   period_wrap;
    logic [ast_pkg::LEVEL_W-1:0]  compare_level;
    logic [ast_pkg::ACT_W-1:0]    active_tone;
    logic                         sample_done;

    modport source (output valid, period_wrap, compare_level, active_tone, sample_done,
                    input ready);
    modport sink   (input valid, period_wrap, compare_level, active_tone, sample_done,
                    output ready);
endinterface

FILE: hw/rtl/ast_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Divides the clock rate by a tone frequency, one quotient bit per cycle,
// and saturates the quotient to the wrap width.
// ----------------------------------------------------------------------------
module ast_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ast_pkg::CLK_RATE_W-1:0]   i_dividend,
    input  logic [ast_pkg::TONE_W-1:0]       i_divisor,
    output ast_pkg::t_div_stat               o_stat,
    output logic [ast_pkg::WRAP_W-1:0]       o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [ast_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [ast_pkg::TONE_W-1:0]       r_rem;
    logic [ast_pkg::CLK_RATE_W-1:0]   r_dvd;
    logic [ast_pkg::TONE_W-1:0]       r_dvs;
    logic [ast_pkg::WRAP_W-1:0]       r_quo;
    logic                             r_sat;

    logic [ast_pkg::TONE_W:0]         w_cand;
    logic [ast_pkg::TONE_W:0]         w_diff;
    logic                             w_ge;
    logic                             w_last;

    // The partial remainder stays below the divisor, so the trial value
    // with the next dividend bit appended needs just one extra bit.
    always_comb begin
        w_cand = {r_rem, r_dvd[ast_pkg::CLK_RATE_W-1]};
        w_ge   = (w_cand >= {1'b0, r_dvs});
        w_diff = w_cand - {1'b0, r_dvs};
        w_last = (r_cnt == ast_pkg::DIV_CNT_W'(ast_pkg::DIV_STEPS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= !w_last;
            r_done <= w_last;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ast_pkg::TONE_W-1:0] : w_cand[ast_pkg::TONE_W-1:0];
            r_dvd <= {r_dvd[ast_pkg::CLK_RATE_W-2:0], 1'b0};
            r_quo <= {r_quo[ast_pkg::WRAP_W-2:0], w_ge};
            // A one shifted past the top of the quotient means saturation.
            r_sat <= r_sat | r_quo[ast_pkg::WRAP_W-1];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_sat ? ast_pkg::WRAP_MAX : r_quo;

endmodule

FILE: hw/rtl/ast_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone picker
// Finds the first nonzero tone at or after a start index, wrapping around.
// ----------------------------------------------------------------------------
module ast_pick #(
    parameter int NUM_TONES = ast_pkg::NUM_TONES,
    parameter int PTR_W     = 2
) (
    input  logic [NUM_TONES-1:0] i_nz,
    input  logic [PTR_W-1:0]     i_start,
    output logic [PTR_W-1:0]     o_idx
);

    // Walk the candidates from the farthest to the nearest, so the nearest
    // nonzero entry wins.
    always_comb begin
        logic [PTR_W:0] v_sum;
        o_idx = i_start;
        for (int k = NUM_TONES - 1; k >= 0; k--) begin
            v_sum = {1'b0, i_start} + (PTR_W+1)'(k);
            if (v_sum >= (PTR_W+1)'(NUM_TONES)) begin
                v_sum = v_sum - (PTR_W+1)'(NUM_TONES);
            end
            if (i_nz[v_sum[PTR_W-1:0]]) begin
                o_idx = v_sum[PTR_W-1:0];
            end
        end
    end

endmodule

FILE: hw/rtl/arpeggiated_square_tone_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arpeggiated square tone generator
// Steps an arpeggio through the nonzero tones of a sample and gives the PWM
// wrap and compare level for the tone that is sounding.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction is either a sample load (cmd 0, three tone
// frequencies) or a one-millisecond tick (cmd 1). Every input transaction
// produces exactly one output transaction with the period wrap, compare
// level, index of the sounding tone and the sample-done flag.
// The block works on one item at a time. A tick that does not change the
// tone goes from IDLE to EMIT and reaches the output register from EMIT,
// and the next transaction is taken once the sequencer is back in IDLE. A
// load of a non-silent sample, or a tick that moves to the next tone, also
// runs the bit-serial divider (one quotient bit per cycle) through SEL and
// DIV before EMIT; the block takes no new transaction until it is back in
// IDLE, so that divider sets the item rate.
// The result sits in an output register, so the next input transaction is
// taken while the previous result still waits. When the receiver stalls, a
// finished result waits in the sequencer until the output register drains.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle. Reset (synchronous, active low) restores the register
// defaults, clears the tones, and reports silence with the sample done.
// ----------------------------------------------------------------------------
module arpeggiated_square_tone_generator_top #(
    parameter int NUM_TONES = ast_pkg::NUM_TONES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ast_pkg::CFG_ADDR_W-1:0]   i_cfg_idx,
    input  logic [ast_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ast_in_if.sink                           i_in_ch,
    ast_out_if.source                        o_out_ch
);

    localparam int PTR_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

    // Configuration registers.
    logic [ast_pkg::CLK_RATE_W-1:0] r_clock_rate;
    logic [ast_pkg::SLICE_W-1:0]    r_slice_ms;
    logic [ast_pkg::SAMPLE_W-1:0]   r_sample_ms;

    // Arpeggio state.
    logic [ast_pkg::TONE_W-1:0]     r_tone [NUM_TONES];
    logic [NUM_TONES-1:0]           r_nz;
    logic                           r_silent;
    logic [PTR_W-1:0]               r_ptr;
    logic [PTR_W-1:0]               r_start;
    logic [ast_pkg::SLICE_W-1:0]    r_slice;
    logic [ast_pkg::SAMPLE_W-1:0]   r_elapsed;
    logic [ast_pkg::WRAP_W-1:0]     r_wrap;
    logic                           r_done;

    ast_pkg::t_state                r_state;
    ast_pkg::t_state                n_state;

    // Output register.
    logic                           r_out_valid;
    logic [ast_pkg::WRAP_W-1:0]     r_out_wrap;
    logic [ast_pkg::LEVEL_W-1:0]    r_out_level;
    logic [ast_pkg::ACT_W-1:0]      r_out_act;
    logic                           r_out_done;

    logic                           w_accept;
    logic                           w_in_ready;
    logic                           w_div_start;
    logic                           w_out_load;
    logic [ast_pkg::TONE_W-1:0]     w_ld [NUM_TONES];
    logic [NUM_TONES-1:0]           w_ld_nz;
    logic [ast_pkg::SLICE_W-1:0]    n_slice;
    logic [ast_pkg::SAMPLE_W-1:0]   n_elapsed;
    logic                           w_slice_end;
    logic                           w_time_up;
    logic [PTR_W-1:0]               w_ptr_next;
    logic [PTR_W-1:0]               w_pick_idx;
    ast_pkg::t_div_stat             w_div_stat;
    logic [ast_pkg::WRAP_W-1:0]     w_div_quo;
    logic [ast_pkg::PTR_FULL_W-1:0] w_ptr_full;

    // ------------------------------------------------------------------
    // Configuration port. Writes to an unused index are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= ast_pkg::CLOCK_RATE_RST;
            r_slice_ms   <= ast_pkg::SLICE_MS_RST;
            r_sample_ms  <= ast_pkg::SAMPLE_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ast_pkg::CFG_CLOCK_RATE: r_clock_rate <= i_cfg_data;
                ast_pkg::CFG_SLICE_MS:   r_slice_ms   <= i_cfg_data[ast_pkg::SLICE_W-1:0];
                ast_pkg::CFG_SAMPLE_MS:  r_sample_ms  <= i_cfg_data[ast_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Incoming sample: tones beyond the three input fields load as zero.
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < NUM_TONES; i++) begin
            if (i == 0) begin
                w_ld[i] = i_in_ch.tone_a;
            end else if (i == 1) begin
                w_ld[i] = i_in_ch.tone_b;
            end else if (i == 2) begin
                w_ld[i] = i_in_ch.tone_c;
            end else begin
                w_ld[i] = '0;
            end
            w_ld_nz[i] = (w_ld[i] != '0);
        end
    end

    // Tick bookkeeping: both counters saturate.
    always_comb begin
        n_elapsed   = (r_elapsed == ast_pkg::ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
        n_slice     = (r_slice == ast_pkg::SLICE_MAX) ? r_slice : r_slice + 1'b1;
        w_time_up   = (n_elapsed >= r_sample_ms);
        w_slice_end = (n_slice >= r_slice_ms);
        w_ptr_next  = (r_ptr == PTR_W'(NUM_TONES - 1)) ? '0 : r_ptr + 1'b1;
    end

    ast_pick #(
        .NUM_TONES (NUM_TONES),
        .PTR_W     (PTR_W)
    ) u_pick (
        .i_nz    (r_nz),
        .i_start (r_start),
        .o_idx   (w_pick_idx)
    );

    ast_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_clock_rate),
        .i_divisor  (r_tone[w_pick_idx]),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quo)
    );

    // ------------------------------------------------------------------
    // Sequencer. IDLE takes a transaction and updates the counters; SEL
    // picks the next sounding tone and launches the divider; DIV waits for
    // the wrap; EMIT hands the result to the output register.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ast_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_in_ch.cmd == ast_pkg::CMD_LOAD) begin
                        n_state = (w_ld_nz != '0) ? ast_pkg::S_SEL : ast_pkg::S_EMIT;
                    end else if (!r_done && !r_silent && w_slice_end && !w_time_up) begin
                        n_state = ast_pkg::S_SEL;
                    end else begin
                        n_state = ast_pkg::S_EMIT;
                    end
                end
            end
            ast_pkg::S_SEL:  n_state = ast_pkg::S_DIV;
            ast_pkg::S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ast_pkg::S_EMIT;
                end
            end
            ast_pkg::S_EMIT: begin
                if (w_out_load) begin
                    n_state = ast_pkg::S_IDLE;
                end
            end
            default: n_state = ast_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = (r_state == ast_pkg::S_IDLE);
        w_div_start = (r_state == ast_pkg::S_SEL);
        w_out_load  = (r_state == ast_pkg::S_EMIT) && (!r_out_valid || o_out_ch.ready);
    end

    assign w_accept = i_in_ch.valid && w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ast_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Arpeggio state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TONES; i++) begin
                r_tone[i] <= '0;
            end
            r_nz      <= '0;
            r_silent  <= 1'b1;
            r_ptr     <= '0;
            r_start   <= '0;
            r_slice   <= '0;
            r_elapsed <= '0;
            r_wrap    <= '0;
            r_done    <= 1'b1;
        end else begin
            if (w_accept) begin
                if (i_in_ch.cmd == ast_pkg::CMD_LOAD) begin
                    for (int i = 0; i < NUM_TONES; i++) begin
                        r_tone[i] <= w_ld[i];
                    end
                    r_nz      <= w_ld_nz;
                    r_silent  <= (w_ld_nz == '0);
                    r_slice   <= '0;
                    r_elapsed <= '0;
                    r_done    <= 1'b0;
                    r_start   <= '0;
                    if (w_ld_nz == '0) begin
                        r_ptr <= '0;
                    end
                end else if (!r_done) begin
                    r_elapsed <= n_elapsed;
                    if (r_silent) begin
                        r_slice <= n_slice;
                        if (w_time_up) begin
                            r_done <= 1'b1;
                        end
                    end else if (w_slice_end) begin
                        r_slice <= '0;
                        if (w_time_up) begin
                            r_done <= 1'b1;
                        end else begin
                            r_start <= w_ptr_next;
                        end
                    end else begin
                        r_slice <= n_slice;
                    end
                end
            end
            if (w_div_start) begin
                r_ptr <= w_pick_idx;
            end
            if ((r_state == ast_pkg::S_DIV) && w_div_stat.done) begin
                r_wrap <= w_div_quo;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    assign w_ptr_full = ast_pkg::PTR_FULL_W'(r_ptr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_wrap  <= r_wrap;
            r_out_level <= r_silent ? '0 : r_wrap[ast_pkg::WRAP_W-1:1];
            r_out_act   <= w_ptr_full[ast_pkg::ACT_W-1:0];
            r_out_done  <= r_done;
        end
    end

    assign i_in_ch.ready          = w_in_ready;
    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.period_wrap   = r_out_wrap;
    assign o_out_ch.compare_level = r_out_level;
    assign o_out_ch.active_tone   = r_out_act;
    assign o_out_ch.sample_done   = r_out_done;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The divider only runs while the sequencer waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> (r_state == ast_pkg::S_DIV))
        else $error("divider busy outside the divide state");

    // A shown compare level is either silence or half the shown wrap.
    a_level_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_level == '0)
                         || (r_out_level == r_out_wrap[ast_pkg::WRAP_W-1:1])))
        else $error("compare level is not half the wrap");

    // A tick after the sample has ended goes straight to the result.
    a_done_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_ch.cmd == ast_pkg::CMD_TICK) && r_done)
        |=> (r_state == ast_pkg::S_EMIT))
        else $error("tick after sample end did not go to emit");

    // The tone pointer never leaves the tone store.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) < NUM_TONES)
        else $error("tone pointer out of range");

endmodule
